// ===== src/fixed_point_alu_assert.svh =====
// Assertion macros for the fixed-point ALU checker.
// Depends on nothing; expects clk and rst in the scope where the macros are used.
`ifndef FIXED_POINT_ALU_ASSERT_SVH
`define FIXED_POINT_ALU_ASSERT_SVH

// Checked only out of reset
`define FPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included
`define FPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/fpa_pkg.sv =====
// Shared types and constants for the fixed-point ALU.
// Holds opcodes, microcode fields, the control bundle and the factorial table.
package fpa_pkg;

  localparam int WORD_W = 32;
  localparam int ARG_W  = 8;
  localparam int OP_W   = 3;
  localparam int PC_W   = 4;

  // Opcodes
  localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd2;
  localparam logic [OP_W-1:0] OP_POW  = 3'd3;
  localparam logic [OP_W-1:0] OP_FACT = 3'd4;

  // Accumulator sources
  localparam logic [2:0] ACC_HOLD = 3'd0;
  localparam logic [2:0] ACC_ADD  = 3'd1;
  localparam logic [2:0] ACC_SUB  = 3'd2;
  localparam logic [2:0] ACC_PROD = 3'd3;
  localparam logic [2:0] ACC_ONE  = 3'd4;
  localparam logic [2:0] ACC_FACT = 3'd5;
  localparam logic [2:0] ACC_ZERO = 3'd6;

  // Multiplier operand selects
  localparam logic MUL_AB    = 1'b0;
  localparam logic MUL_ACC_A = 1'b1;

  // Jump conditions
  localparam logic [1:0] JMP_NONE   = 2'd0;
  localparam logic [1:0] JMP_ALWAYS = 2'd1;
  localparam logic [1:0] JMP_LE0    = 2'd2;

  // Microcode entry points and shared exit step
  localparam logic [PC_W-1:0] PC_ADD  = 4'd0;
  localparam logic [PC_W-1:0] PC_SUB  = 4'd1;
  localparam logic [PC_W-1:0] PC_MUL  = 4'd2;
  localparam logic [PC_W-1:0] PC_MUL2 = 4'd3;
  localparam logic [PC_W-1:0] PC_POW  = 4'd4;
  localparam logic [PC_W-1:0] PC_POWT = 4'd5;
  localparam logic [PC_W-1:0] PC_POWA = 4'd6;
  localparam logic [PC_W-1:0] PC_FACT = 4'd7;
  localparam logic [PC_W-1:0] PC_ZERO = 4'd8;
  localparam logic [PC_W-1:0] PC_DONE = 4'd9;

  typedef struct packed {
    logic [2:0]      acc_op;
    logic            mul_en;
    logic            mul_sel;
    logic            cnt_dec;
    logic [1:0]      jmp;
    logic [PC_W-1:0] target;
    logic            done;
  } ucode_t;

  // Control from sequencer to datapath
  typedef struct packed {
    logic       load;
    logic [2:0] acc_op;
    logic       mul_en;
    logic       mul_sel;
    logic       cnt_dec;
  } ctrl_t;

  // n! for n in 0..6, zero elsewhere
  function automatic logic [9:0] fact_lut(input logic signed [ARG_W-1:0] n);
    logic [9:0] f;
    case (n)
      8'sd0:   f = 10'd1;
      8'sd1:   f = 10'd1;
      8'sd2:   f = 10'd2;
      8'sd3:   f = 10'd6;
      8'sd4:   f = 10'd24;
      8'sd5:   f = 10'd120;
      8'sd6:   f = 10'd720;
      default: f = 10'd0;
    endcase
    return f;
  endfunction

endpackage

// ===== src/fpa_seq.sv =====
// Microcode sequencer: step counter, control-word ROM and jump logic.
// Depends on fpa_pkg.
module fpa_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [fpa_pkg::OP_W-1:0]      op,
  input  logic                          out_full,
  input  logic                          cnt_le0,
  output logic                          in_ready,
  output logic                          out_load,
  output fpa_pkg::ctrl_t                ctrl
);

  logic                          busy;
  logic [fpa_pkg::PC_W-1:0]      pc;
  logic [fpa_pkg::PC_W-1:0]      entry;
  fpa_pkg::ucode_t               uw;
  logic                          accept;
  logic                          taken;

  function automatic fpa_pkg::ucode_t mk(
    input logic [2:0]               acc_op,
    input logic                     mul_en,
    input logic                     mul_sel,
    input logic                     cnt_dec,
    input logic [1:0]               jmp,
    input logic [fpa_pkg::PC_W-1:0] target,
    input logic                     done
  );
    fpa_pkg::ucode_t w;
    w.acc_op  = acc_op;
    w.mul_en  = mul_en;
    w.mul_sel = mul_sel;
    w.cnt_dec = cnt_dec;
    w.jmp     = jmp;
    w.target  = target;
    w.done    = done;
    return w;
  endfunction

  // Control ROM
  always_comb begin
    unique case (pc)
      fpa_pkg::PC_ADD:  uw = mk(fpa_pkg::ACC_ADD, 1'b0, fpa_pkg::MUL_AB, 1'b0,
                                fpa_pkg::JMP_ALWAYS, fpa_pkg::PC_DONE, 1'b0);
      fpa_pkg::PC_SUB:  uw = mk(fpa_pkg::ACC_SUB, 1'b0, fpa_pkg::MUL_AB, 1'b0,
                                fpa_pkg::JMP_ALWAYS, fpa_pkg::PC_DONE, 1'b0);
      fpa_pkg::PC_MUL:  uw = mk(fpa_pkg::ACC_HOLD, 1'b1, fpa_pkg::MUL_AB, 1'b0,
                                fpa_pkg::JMP_NONE, fpa_pkg::PC_DONE, 1'b0);
      fpa_pkg::PC_MUL2: uw = mk(fpa_pkg::ACC_PROD, 1'b0, fpa_pkg::MUL_AB, 1'b0,
                                fpa_pkg::JMP_ALWAYS, fpa_pkg::PC_DONE, 1'b0);
      fpa_pkg::PC_POW:  uw = mk(fpa_pkg::ACC_ONE, 1'b0, fpa_pkg::MUL_AB, 1'b0,
                                fpa_pkg::JMP_NONE, fpa_pkg::PC_DONE, 1'b0);
      // exit when the exponent count runs out, else multiply once more
      fpa_pkg::PC_POWT: uw = mk(fpa_pkg::ACC_HOLD, 1'b1, fpa_pkg::MUL_ACC_A, 1'b1,
                                fpa_pkg::JMP_LE0, fpa_pkg::PC_DONE, 1'b0);
      fpa_pkg::PC_POWA: uw = mk(fpa_pkg::ACC_PROD, 1'b0, fpa_pkg::MUL_AB, 1'b0,
                                fpa_pkg::JMP_ALWAYS, fpa_pkg::PC_POWT, 1'b0);
      fpa_pkg::PC_FACT: uw = mk(fpa_pkg::ACC_FACT, 1'b0, fpa_pkg::MUL_AB, 1'b0,
                                fpa_pkg::JMP_ALWAYS, fpa_pkg::PC_DONE, 1'b0);
      fpa_pkg::PC_ZERO: uw = mk(fpa_pkg::ACC_ZERO, 1'b0, fpa_pkg::MUL_AB, 1'b0,
                                fpa_pkg::JMP_NONE, fpa_pkg::PC_DONE, 1'b0);
      default:          uw = mk(fpa_pkg::ACC_HOLD, 1'b0, fpa_pkg::MUL_AB, 1'b0,
                                fpa_pkg::JMP_NONE, fpa_pkg::PC_DONE, 1'b1);
    endcase
  end

  // Opcode dispatch
  always_comb begin
    unique case (op)
      fpa_pkg::OP_ADD:  entry = fpa_pkg::PC_ADD;
      fpa_pkg::OP_SUB:  entry = fpa_pkg::PC_SUB;
      fpa_pkg::OP_MUL:  entry = fpa_pkg::PC_MUL;
      fpa_pkg::OP_POW:  entry = fpa_pkg::PC_POW;
      fpa_pkg::OP_FACT: entry = fpa_pkg::PC_FACT;
      default:          entry = fpa_pkg::PC_ZERO;
    endcase
  end

  assign in_ready = !busy;
  assign accept   = in_valid && !busy;
  assign taken    = (uw.jmp == fpa_pkg::JMP_ALWAYS) ||
                    ((uw.jmp == fpa_pkg::JMP_LE0) && cnt_le0);
  assign out_load = busy && uw.done && !out_full;

  // Datapath controls, gated by busy
  always_comb begin
    ctrl.load    = accept;
    ctrl.acc_op  = busy ? uw.acc_op : fpa_pkg::ACC_HOLD;
    ctrl.mul_en  = busy && uw.mul_en;
    ctrl.mul_sel = uw.mul_sel;
    ctrl.cnt_dec = busy && uw.cnt_dec;
  end

  // Step counter; the exit step waits for a free output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= fpa_pkg::PC_ADD;
    end else if (accept) begin
      busy <= 1'b1;
      pc   <= entry;
    end else if (busy) begin
      if (uw.done) begin
        if (!out_full) busy <= 1'b0;
      end else if (taken) begin
        pc <= uw.target;
      end else begin
        pc <= pc + 1'b1;
      end
    end
  end

endmodule

// ===== src/fpa_dp.sv =====
// Datapath: operand registers, exponent counter, registered multiplier, accumulator.
// Depends on fpa_pkg; driven by the control bundle from fpa_seq.
module fpa_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  fpa_pkg::ctrl_t                        ctrl,
  input  logic signed [fpa_pkg::WORD_W-1:0]     operand_a,
  input  logic signed [fpa_pkg::WORD_W-1:0]     operand_b,
  input  logic signed [fpa_pkg::ARG_W-1:0]      int_arg,
  output logic                                  cnt_le0,
  output logic signed [fpa_pkg::WORD_W-1:0]     acc
);

  logic signed [fpa_pkg::WORD_W-1:0]     a_r;
  logic signed [fpa_pkg::WORD_W-1:0]     b_r;
  logic signed [fpa_pkg::ARG_W-1:0]      cnt;
  logic signed [2*fpa_pkg::WORD_W-1:0]   prod;
  logic signed [fpa_pkg::WORD_W-1:0]     mul_l;
  logic signed [fpa_pkg::WORD_W-1:0]     mul_r;
  logic signed [2*fpa_pkg::WORD_W-1:0]   mul_p;
  logic signed [fpa_pkg::WORD_W-1:0]     acc_next;
  logic        [fpa_pkg::WORD_W-1:0]     fact_w;
  logic        [fpa_pkg::WORD_W-1:0]     one_w;

  assign one_w   = fpa_pkg::WORD_W'(1) << FRAC_BITS;
  assign fact_w  = fpa_pkg::WORD_W'(fpa_pkg::fact_lut(cnt)) << FRAC_BITS;
  assign cnt_le0 = cnt[fpa_pkg::ARG_W-1] || (cnt == '0);

  // Multiplier: left operand is a or the accumulator, right is b or a
  assign mul_l = (ctrl.mul_sel == fpa_pkg::MUL_ACC_A) ? acc : a_r;
  assign mul_r = (ctrl.mul_sel == fpa_pkg::MUL_ACC_A) ? a_r : b_r;
  assign mul_p = (2*fpa_pkg::WORD_W)'(mul_l) * (2*fpa_pkg::WORD_W)'(mul_r);

  // Accumulator source select; shifted product keeps its low word
  always_comb begin
    case (ctrl.acc_op)
      fpa_pkg::ACC_ADD:  acc_next = a_r + b_r;
      fpa_pkg::ACC_SUB:  acc_next = a_r - b_r;
      fpa_pkg::ACC_PROD: acc_next = prod[FRAC_BITS +: fpa_pkg::WORD_W];
      fpa_pkg::ACC_ONE:  acc_next = one_w;
      fpa_pkg::ACC_FACT: acc_next = fact_w;
      fpa_pkg::ACC_ZERO: acc_next = '0;
      default:           acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      a_r <= operand_a;
      b_r <= operand_b;
    end
    if (ctrl.load)         cnt <= int_arg;
    else if (ctrl.cnt_dec) cnt <= cnt - 1'b1;
    if (ctrl.mul_en) prod <= mul_p;
    acc <= acc_next;
  end

endmodule

// ===== src/fixed_point_alu.sv =====
// Add, subtract, factorial and unused opcodes run their own ROM step, then the exit
// step; multiply runs a multiply step, then an accumulate step; power loads 1.0 and
// repeats its registered multiply-and-reload loop max(int_arg, 0) times on one
// shared multiplier. One item at a time; the next item is accepted the cycle after the
// result enters the output register, even while that result waits for out_ready.
// Reset (synchronous, rst high) idles the sequencer and empties the output register.
module fixed_point_alu #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [fpa_pkg::OP_W-1:0]            op,
  input  logic signed [fpa_pkg::WORD_W-1:0]   operand_a,
  input  logic signed [fpa_pkg::WORD_W-1:0]   operand_b,
  input  logic signed [fpa_pkg::ARG_W-1:0]    int_arg,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [fpa_pkg::WORD_W-1:0]   result
);

  fpa_pkg::ctrl_t                      ctrl;
  logic                                cnt_le0;
  logic                                out_load;
  logic                                out_full;
  logic signed [fpa_pkg::WORD_W-1:0]   acc;

  assign out_full = out_valid && !out_ready;

  fpa_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .out_full (out_full),
    .cnt_le0  (cnt_le0),
    .in_ready (in_ready),
    .out_load (out_load),
    .ctrl     (ctrl)
  );

  fpa_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .ctrl      (ctrl),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .int_arg   (int_arg),
    .cnt_le0   (cnt_le0),
    .acc       (acc)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) result <= acc;
  end

endmodule

// ===== src/fpa_checker.sv =====
// Port-level checker for fixed_point_alu, bound to the top level.
// Depends on fpa_pkg and fixed_point_alu_assert.svh.
`include "fixed_point_alu_assert.svh"

module fpa_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [fpa_pkg::OP_W-1:0]            op,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [fpa_pkg::WORD_W-1:0]   result
);

  logic stalled;
  logic add_xfer;

  // Result waiting on the receiver
  assign stalled  = out_valid && !out_ready;
  // Add transfer while the output is empty
  assign add_xfer = in_valid && in_ready && (op == fpa_pkg::OP_ADD) && !out_valid;

  // A stalled result holds
  `FPA_ASSERT(a_out_hold, stalled |=> out_valid && $stable(result), "result changed while stalled")

  // One item at a time: no transfer right after a transfer
  `FPA_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "input taken while busy")

  // Add into an empty output shows up after the add step, the exit step and the output register
  `FPA_ASSERT(a_add_lat, add_xfer |-> ##3 out_valid, "add result late")

  // Reset empties the output
  `FPA_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "output valid after reset")

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Q16.16 fixed-point ALU (fixed_point_alu).
// Depends on fpa_pkg for widths and opcodes; predicts every result in-bench.

module testbench;

  localparam int WORD_W        = fpa_pkg::WORD_W;
  localparam int ARG_W         = fpa_pkg::ARG_W;
  localparam int OP_W          = fpa_pkg::OP_W;

  localparam int FRAC_BITS     = 16;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int PHASE1_AT     = 700;
  localparam int PHASE2_AT     = 1400;
  localparam int HOLD_AT       = 1700;
  localparam int HOLD_LEN      = 500;
  localparam int DRAIN_CYCLES  = 300;
  localparam int LIMIT_CYCLES  = 3_000_000;
  localparam int MAX_REPORTS   = 10;

  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] UNIT     = 32'sd1 <<< FRAC_BITS;

  // Opcodes the block does not define; they must return zero
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = fpa_pkg::OP_FACT + 3'd1;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = '1;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;
    logic signed [ARG_W-1:0]  k;
  } alu_item_t;

  typedef struct {
    alu_item_t         item;
    logic [WORD_W-1:0] value;
  } alu_expect_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // DUT ports
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic [OP_W-1:0]          op        = '0;
  logic signed [WORD_W-1:0] operand_a = '0;
  logic signed [WORD_W-1:0] operand_b = '0;
  logic signed [ARG_W-1:0]  int_arg   = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [WORD_W-1:0] result;

  fixed_point_alu #(.FRAC_BITS(FRAC_BITS)) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .int_arg   (int_arg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  // Pending stimulus and predicted results
  alu_item_t   pending_items[$];
  alu_expect_t predicted_results[$];
  alu_item_t   driven_item;
  alu_expect_t oldest_result;

  int accepted_count = 0;
  int total_items    = 0;
  int checked_count  = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;
  int op_count[8]    = '{default: 0};

  logic holding   = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Full 64-bit product, arithmetic shift, low word kept
  function automatic logic [WORD_W-1:0] fx_product(logic signed [WORD_W-1:0] x,
                                                   logic signed [WORD_W-1:0] y);
    logic signed [63:0] wx;
    logic signed [63:0] wy;
    logic signed [63:0] wide;
    wx   = 64'(x);
    wy   = 64'(y);
    wide = wx * wy;
    wide = wide >>> FRAC_BITS;
    return wide[WORD_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] fx_power(logic signed [WORD_W-1:0] base,
                                                 logic signed [ARG_W-1:0] exponent);
    logic [WORD_W-1:0] acc;
    int                e;
    acc = UNIT;
    e   = int'(exponent);
    for (int i = 0; i < e; i++)
      acc = fx_product(acc, base);
    return acc;
  endfunction

  function automatic logic [WORD_W-1:0] fx_factorial(logic signed [ARG_W-1:0] arg);
    int          n;
    int unsigned f;
    n = int'(arg);
    if (n < 0 || n > 6)
      return '0;
    f = 1;
    for (int i = 2; i <= n; i++)
      f = f * i;
    return WORD_W'(f << FRAC_BITS);
  endfunction

  function automatic logic [WORD_W-1:0] alu_predict(alu_item_t it);
    logic [WORD_W-1:0] r;
    case (it.op)
      fpa_pkg::OP_ADD:  r = it.a + it.b;
      fpa_pkg::OP_SUB:  r = it.a - it.b;
      fpa_pkg::OP_MUL:  r = fx_product(it.a, it.b);
      fpa_pkg::OP_POW:  r = fx_power(it.a, it.k);
      fpa_pkg::OP_FACT: r = fx_factorial(it.k);
      default:          r = '0;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_item(logic [OP_W-1:0] o, logic signed [WORD_W-1:0] a,
                            logic signed [WORD_W-1:0] b, logic signed [ARG_W-1:0] k);
    alu_item_t it;
    it.op = o;
    it.a  = a;
    it.b  = b;
    it.k  = k;
    pending_items.push_back(it);
  endtask

  // Any 8-bit argument
  function automatic logic signed [ARG_W-1:0] rand_arg();
    return ARG_W'($urandom());
  endfunction

  function automatic logic signed [WORD_W-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      1: begin
        case ($urandom_range(0, 5))
          0: return WORD_MAX;
          1: return WORD_MIN;
          2: return '0;
          3: return -32'sd1;
          4: return UNIT;
          default: return -UNIT;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // Bases near 1.0 keep long power chains meaningful
  function automatic logic signed [WORD_W-1:0] rand_base();
    case ($urandom_range(0, 4))
      0: return $urandom_range(32'h0000_c000, 32'h0001_4000);
      1: return -$signed($urandom_range(32'h0000_c000, 32'h0001_4000));
      2: return $signed($urandom_range(0, 4)) <<< FRAC_BITS;
      3: return rand_operand();
      default: return $urandom();
    endcase
  endfunction

  // Mostly short exponents, some long and negative ones
  function automatic logic signed [ARG_W-1:0] rand_exponent();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return ARG_W'($urandom_range(0, 12));
      6: return ARG_W'($urandom_range(13, 40));
      7: return ARG_W'(-$signed($urandom_range(1, 128)));
      default: return rand_arg();
    endcase
  endfunction

  function automatic logic signed [ARG_W-1:0] rand_fact_arg();
    if ($urandom_range(0, 9) < 6)
      return ARG_W'($urandom_range(0, 6));
    return rand_arg();
  endfunction

  // Idle percentage by phase: receiver-heavy, sender-heavy, then none
  function automatic int idle_pct(bit sender);
    if (accepted_count < PHASE1_AT)
      return sender ? 32 : 55;
    if (accepted_count < PHASE2_AT)
      return sender ? 55 : 32;
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents pending items, records each transfer's prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_results.push_back('{item: driven_item,
                                      value: alu_predict(driven_item)});
        accepted_count <= accepted_count + 1;
        op_count[driven_item.op] <= op_count[driven_item.op] + 1;
      end
      if (in_valid && !in_ready) begin
        // hold the offered item until it transfers
      end else if (pending_items.size() != 0 &&
                   $urandom_range(0, 99) >= idle_pct(1'b1)) begin
        driven_item = pending_items.pop_front();
        op        <= driven_item.op;
        operand_a <= driven_item.a;
        operand_b <= driven_item.b;
        int_arg   <= driven_item.k;
        in_valid  <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long receiver hold-off so the block fills and stalls its input
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      holding   <= 1'b0;
      hold_done <= 1'b0;
      hold_left <= 0;
    end else if (!hold_done && accepted_count >= HOLD_AT) begin
      holding   <= 1'b1;
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
    end else if (holding) begin
      if (hold_left <= 1)
        holding <= 1'b0;
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result transfer with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("ERROR: result %h arrived with no prediction pending", result);
        end else begin
          oldest_result = predicted_results.pop_front();
          checked_count++;
          if (result !== oldest_result.value) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("ERROR: op %0d a %h b %h k %0d: result expected %h, got %h",
                       oldest_result.item.op, oldest_result.item.a,
                       oldest_result.item.b, oldest_result.item.k,
                       oldest_result.value, result);
          end
        end
      end
      out_ready <= !holding && ($urandom_range(0, 99) >= idle_pct(1'b0));
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d of %0d items transferred",
               cycle_count, accepted_count, total_items);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    // Wrapping add and subtract at the word limits
    queue_item(fpa_pkg::OP_ADD, WORD_MAX, 32'sd1, rand_arg());
    queue_item(fpa_pkg::OP_ADD, WORD_MIN, WORD_MIN, rand_arg());
    queue_item(fpa_pkg::OP_SUB, WORD_MIN, 32'sd1, rand_arg());
    queue_item(fpa_pkg::OP_SUB, '0, WORD_MIN, rand_arg());
    // Multiply extremes and the rounding of small negative products
    queue_item(fpa_pkg::OP_MUL, WORD_MAX, WORD_MAX, rand_arg());
    queue_item(fpa_pkg::OP_MUL, WORD_MIN, WORD_MIN, rand_arg());
    queue_item(fpa_pkg::OP_MUL, WORD_MIN, WORD_MAX, rand_arg());
    queue_item(fpa_pkg::OP_MUL, -32'sd1, 32'sd1, rand_arg());
    queue_item(fpa_pkg::OP_MUL, UNIT, UNIT, rand_arg());
    // Power: longest chains, zero and negative exponents
    queue_item(fpa_pkg::OP_POW, UNIT, $urandom(), 8'sd127);
    queue_item(fpa_pkg::OP_POW, 32'sh0001_0001, $urandom(), 8'sd127);
    queue_item(fpa_pkg::OP_POW, -UNIT, $urandom(), 8'sd127);
    queue_item(fpa_pkg::OP_POW, UNIT <<< 1, $urandom(), 8'sd20);
    queue_item(fpa_pkg::OP_POW, $urandom(), $urandom(), 8'sd0);
    queue_item(fpa_pkg::OP_POW, $urandom(), $urandom(), -8'sd1);
    queue_item(fpa_pkg::OP_POW, WORD_MAX, $urandom(), -8'sd128);
    // Factorial in range and out of range on both sides
    queue_item(fpa_pkg::OP_FACT, $urandom(), $urandom(), -8'sd128);
    queue_item(fpa_pkg::OP_FACT, $urandom(), $urandom(), -8'sd1);
    queue_item(fpa_pkg::OP_FACT, $urandom(), $urandom(), 8'sd0);
    queue_item(fpa_pkg::OP_FACT, $urandom(), $urandom(), 8'sd3);
    queue_item(fpa_pkg::OP_FACT, $urandom(), $urandom(), 8'sd6);
    queue_item(fpa_pkg::OP_FACT, $urandom(), $urandom(), 8'sd7);
    queue_item(fpa_pkg::OP_FACT, $urandom(), $urandom(), 8'sd127);
    // Undefined opcodes
    queue_item(OP_SPARE_FIRST, $urandom(), $urandom(), rand_arg());
    queue_item(OP_SPARE_FIRST + 3'd1, $urandom(), $urandom(), rand_arg());
    queue_item(OP_SPARE_LAST, $urandom(), $urandom(), rand_arg());

    // Random mix weighted toward the arithmetic operations
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ($urandom_range(0, 99)) inside
        [0:19]:  queue_item(fpa_pkg::OP_ADD, rand_operand(), rand_operand(), rand_arg());
        [20:39]: queue_item(fpa_pkg::OP_SUB, rand_operand(), rand_operand(), rand_arg());
        [40:64]: queue_item(fpa_pkg::OP_MUL, rand_operand(), rand_operand(), rand_arg());
        [65:79]: queue_item(fpa_pkg::OP_POW, rand_base(), $urandom(), rand_exponent());
        [80:91]: queue_item(fpa_pkg::OP_FACT, $urandom(), $urandom(), rand_fact_arg());
        default: queue_item(OP_SPARE_FIRST + OP_W'($urandom_range(0, 2)),
                            $urandom(), $urandom(), rand_arg());
      endcase
    end
    total_items = pending_items.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (accepted_count != total_items) @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d transfers: add %0d, sub %0d, mul %0d, pow %0d, fact %0d",
             accepted_count, op_count[fpa_pkg::OP_ADD], op_count[fpa_pkg::OP_SUB],
             op_count[fpa_pkg::OP_MUL], op_count[fpa_pkg::OP_POW],
             op_count[fpa_pkg::OP_FACT]);
    $display("undefined %0d; %0d results checked in %0d cycles, %0d-cycle hold, %0d mismatches",
             op_count[OP_SPARE_FIRST] + op_count[OP_SPARE_FIRST + 3'd1] +
             op_count[OP_SPARE_LAST], checked_count, cycle_count, HOLD_LEN,
             mismatch_count);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
